>>> hdl/brpd_pkg.sv
// Shared package for the byte ring buffer with packet drain.
// Holds default sizes, input codes and the controller/datapath command and status types.
// No dependencies.
`timescale 1ns / 1ps

package brpd_pkg;

    localparam int DEPTH_DEF  = 256;
    localparam int PACKET_DEF = 64;

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_USER_W = 2;

    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    typedef struct packed {
        logic store;
        logic load;
        logic solo;
        logic step;
        logic refused;
    } brpd_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic last;
    } brpd_sts_t;

endpackage

>>> hdl/brpd_dp.sv
// Datapath of the byte ring buffer: byte store, write and read indexes,
// packet length, output byte register and flags.
// Depends on brpd_pkg.
`timescale 1ns / 1ps

module brpd_dp #(
    parameter int DEPTH  = brpd_pkg::DEPTH_DEF,
    parameter int PACKET = brpd_pkg::PACKET_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  brpd_pkg::brpd_cmd_t  cmd,
    input  logic [7:0]           data_byte,
    output brpd_pkg::brpd_sts_t  sts,
    output logic                 data_valid,
    output logic [7:0]           out_byte,
    output logic                 byte_refused
);
    import brpd_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(PACKET + 1);
    localparam int LW = (IW + 1 > CW) ? IW + 1 : CW;

    logic [7:0]    mem [DEPTH];
    logic [IW-1:0] w_reg;
    logic [IW-1:0] w_next;
    logic [IW-1:0] r_reg;
    logic [IW-1:0] r_next;
    logic [IW-1:0] cur_reg;
    logic [IW-1:0] cur_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          dvalid_reg;
    logic          dvalid_next;
    logic          refused_reg;
    logic          refused_next;
    logic [7:0]    rdata_reg;

    logic [IW-1:0] w_inc;
    logic [IW-1:0] cur_inc;
    logic [LW-1:0] span;
    logic [CW-1:0] len;
    logic [LW-1:0] r_sum;
    logic          rd_en;
    logic [IW-1:0] rd_addr;

    always_comb
    begin
        w_inc   = (w_reg == IW'(DEPTH - 1)) ? '0 : w_reg + 1'b1;
        cur_inc = (cur_reg == IW'(DEPTH - 1)) ? '0 : cur_reg + 1'b1;
        if (w_reg > r_reg)
        begin
            span = LW'(w_reg) - LW'(r_reg);
        end
        else
        begin
            span = LW'(DEPTH) - LW'(r_reg);
        end
        len   = (span > LW'(PACKET)) ? CW'(PACKET) : span[CW-1:0];
        r_sum = LW'(r_reg) + LW'(len);
    end

    assign sts.full  = (w_inc == r_reg);
    assign sts.empty = (w_reg == r_reg);
    assign sts.last  = (cnt_reg == CW'(1));

    assign rd_en   = cmd.load | cmd.step;
    assign rd_addr = cmd.load ? r_reg : cur_inc;

    always_comb
    begin
        w_next       = w_reg;
        r_next       = r_reg;
        cur_next     = cur_reg;
        cnt_next     = cnt_reg;
        dvalid_next  = dvalid_reg;
        refused_next = refused_reg;
        if (cmd.store)
        begin
            w_next = w_inc;
        end
        if (cmd.load)
        begin
            r_next       = (r_sum == LW'(DEPTH)) ? '0 : r_sum[IW-1:0];
            cur_next     = r_reg;
            cnt_next     = len;
            dvalid_next  = 1'b1;
            refused_next = cmd.refused;
        end
        else if (cmd.solo)
        begin
            cnt_next     = CW'(1);
            dvalid_next  = 1'b0;
            refused_next = 1'b1;
        end
        else if (cmd.step)
        begin
            cur_next = cur_inc;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg       <= '0;
            r_reg       <= '0;
            cur_reg     <= '0;
            cnt_reg     <= '0;
            dvalid_reg  <= 1'b0;
            refused_reg <= 1'b0;
        end
        else
        begin
            w_reg       <= w_next;
            r_reg       <= r_next;
            cur_reg     <= cur_next;
            cnt_reg     <= cnt_next;
            dvalid_reg  <= dvalid_next;
            refused_reg <= refused_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[w_reg] <= data_byte;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign data_valid   = dvalid_reg;
    assign out_byte     = dvalid_reg ? rdata_reg : 8'h00;
    assign byte_refused = refused_reg;

endmodule

>>> hdl/brpd_ctrl.sv
// Controller of the byte ring buffer: decodes each input transfer and
// sequences the packet bytes onto the output channel.
// Depends on brpd_pkg.
`timescale 1ns / 1ps

module brpd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 action,
    input  logic                 endpoint_free,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  brpd_pkg::brpd_sts_t  sts,
    output brpd_pkg::brpd_cmd_t  cmd
);
    import brpd_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_OUT  = 1'b1;

    logic state_reg;
    logic state_next;
    logic in_xfer;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign in_xfer   = in_valid & in_ready;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (action == ACT_BYTE)
                    begin
                        if (!sts.full)
                        begin
                            cmd.store = 1'b1;
                        end
                        else if (endpoint_free)
                        begin
                            cmd.load    = 1'b1;
                            cmd.refused = 1'b1;
                            state_next  = ST_OUT;
                        end
                        else
                        begin
                            cmd.solo   = 1'b1;
                            state_next = ST_OUT;
                        end
                    end
                    else if (endpoint_free && !sts.empty)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (sts.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/byte_ring_buffer_packet_drain_top.sv
// Top level of the byte ring buffer with packet drain.
// Joins brpd_ctrl and brpd_dp; depends on brpd_pkg.
//
// Input channel s_axis: tuser carries the kind of transfer (received byte or
// drain request), tdata the byte and the endpoint-free flag. Output channel
// m_axis: one transfer per packet byte, tlast on the final byte of a packet,
// tuser flags whether tdata holds a byte and whether the run stems from a
// refused byte.
// A received byte that fits is stored and the input stays ready for the next
// transfer. A drain request, or a byte refused on a full buffer, that yields
// a packet of n bytes holds the input until its last byte is taken: the
// first byte appears the cycle after the transfer and the next one follows
// in every cycle that the receiver takes one, paced by the registered read
// port of the byte store. A refused byte with the endpoint busy gives a
// single flag-only transfer. Drains that give no packet leave the input ready.
// While the receiver stalls, the output holds and no input is taken.
// Reset empties the buffer at once; the store itself needs no clearing.
`timescale 1ns / 1ps

module byte_ring_buffer_packet_drain_top #(
    parameter int DEPTH  = brpd_pkg::DEPTH_DEF,
    parameter int PACKET = brpd_pkg::PACKET_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [brpd_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // data_byte, endpoint_free
    input  logic [brpd_pkg::IN_USER_W-1:0]     s_axis_tuser,  // action
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [brpd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // out_byte
    output logic                               m_axis_tlast,
    output logic [brpd_pkg::OUT_USER_W-1:0]    m_axis_tuser   // data_valid, byte_refused
);
    import brpd_pkg::*;

    brpd_cmd_t  cmd;
    brpd_sts_t  sts;
    logic       data_valid;
    logic       byte_refused;

    brpd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .action        (s_axis_tuser[0]),
        .endpoint_free (s_axis_tdata[8]),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    brpd_dp #(
        .DEPTH  (DEPTH),
        .PACKET (PACKET)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .data_byte    (s_axis_tdata[7:0]),
        .sts          (sts),
        .data_valid   (data_valid),
        .out_byte     (m_axis_tdata),
        .byte_refused (byte_refused)
    );

    assign m_axis_tlast = sts.last;
    assign m_axis_tuser = {byte_refused, data_valid};

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a packet is in flight");

    a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("input not reopened after final transfer");

    a_flag_only_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tuser[1]))
        else $error("flag-only transfer not a single refused result");

    a_drain_starts_output: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] && s_axis_tdata[8]
         && !sts.empty) |=> m_axis_tvalid)
        else $error("drain with data and free endpoint gave no packet");

endmodule

>>> tb/byte_ring_buffer_packet_drain_top_tb.sv
// Self-checking testbench for byte_ring_buffer_packet_drain_top: a scoreboard class predicts
// every packet transfer from the accepted inputs and checks the output stream against it.
// Depends on brpd_pkg and the top level; drives randomised traffic with stalls on both sides.
`timescale 1ns / 1ps

module byte_ring_buffer_packet_drain_top_tb;

    import brpd_pkg::*;

    localparam int RING_DEPTH  = DEPTH_DEF;
    localparam int RING_PACKET = PACKET_DEF;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] out_byte;
        logic       last_in_packet;
        logic       byte_refused;
    } drain_beat_t;

    class ring_drain_board;
        logic [7:0]  ring_mem [RING_DEPTH];
        int          wr_idx;
        int          rd_idx;
        drain_beat_t beats_due [$];
        int          errors;

        function new();
            wr_idx = 0;
            rd_idx = 0;
            errors = 0;
        endfunction

        function int free_slots();
            return (rd_idx - wr_idx - 1 + RING_DEPTH) % RING_DEPTH;
        endfunction

        function int pending();
            return beats_due.size();
        endfunction

        function int emit_packet(logic free_ep, logic refused);
            int          len;
            drain_beat_t beat;
            if (wr_idx == rd_idx)
                return 0;
            if (wr_idx > rd_idx)
                len = wr_idx - rd_idx;
            else
                len = RING_DEPTH - rd_idx;
            if (len > RING_PACKET)
                len = RING_PACKET;
            if (!free_ep)
                return 0;
            for (int i = 0; i < len; i++)
            begin
                beat.data_valid     = 1'b1;
                beat.out_byte       = ring_mem[(rd_idx + i) % RING_DEPTH];
                beat.last_in_packet = (i == len - 1);
                beat.byte_refused   = refused;
                beats_due.push_back(beat);
            end
            rd_idx = (rd_idx + len) % RING_DEPTH;
            return len;
        endfunction

        function void note_transfer(logic action, logic [7:0] data, logic free_ep);
            drain_beat_t beat;
            if (action == ACT_DRAIN)
                void'(emit_packet(free_ep, 1'b0));
            else if ((wr_idx + 1) % RING_DEPTH != rd_idx)
            begin
                ring_mem[wr_idx] = data;
                wr_idx = (wr_idx + 1) % RING_DEPTH;
            end
            else if (emit_packet(free_ep, 1'b1) == 0)
            begin
                beat.data_valid     = 1'b0;
                beat.out_byte       = 8'h00;
                beat.last_in_packet = 1'b1;
                beat.byte_refused   = 1'b1;
                beats_due.push_back(beat);
            end
        endfunction

        function void check_beat(logic [7:0] data, logic last, logic [1:0] user);
            drain_beat_t want;
            if (beats_due.size() == 0)
            begin
                $error("unexpected transfer: out_byte %0h tlast %0b tuser %0b", data, last, user);
                errors++;
                return;
            end
            want = beats_due.pop_front();
            if (user[0] !== want.data_valid)
            begin
                $error("data_valid: expected %0b, actual %0b", want.data_valid, user[0]);
                errors++;
            end
            if (data !== want.out_byte)
            begin
                $error("out_byte: expected %02h, actual %02h", want.out_byte, data);
                errors++;
            end
            if (last !== want.last_in_packet)
            begin
                $error("last_in_packet: expected %0b, actual %0b", want.last_in_packet, last);
                errors++;
            end
            if (user[1] !== want.byte_refused)
            begin
                $error("byte_refused: expected %0b, actual %0b", want.byte_refused, user[1]);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // data_byte, endpoint_free
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;   // action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // out_byte
    logic                  m_axis_tlast;
    logic [OUT_USER_W-1:0] m_axis_tuser;        // data_valid, byte_refused

    ring_drain_board sb;
    bit quiet = 1'b0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_len = 0;
    int hold_cnt = 0;
    int stall_cnt = 0;

    byte_ring_buffer_packet_drain_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #20000000;
        $display("status: fail");
        $finish;
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Receiver: long hold on request, otherwise random stalls.
    always @(posedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_cnt  = hold_len;
        end
        if (hold_cnt > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cnt--;
        end
        else if (stall_cnt > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_cnt--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!quiet)
                stall_cnt = rand_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    task automatic offer(logic action, logic [7:0] data, logic free_ep);
        int gap;
        s_axis_tuser  <= action;
        s_axis_tdata  <= {{(IN_DATA_W - 9){1'b0}}, free_ep, data};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_transfer(action, data, free_ep);
        gap = quiet ? 0 : rand_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_byte(logic [7:0] data, logic free_ep);
        offer(ACT_BYTE, data, free_ep);
    endtask

    task automatic send_drain(logic free_ep);
        offer(ACT_DRAIN, 8'($urandom), free_ep);
    endtask

    task automatic fill_ring(int extra);
        int n;
        n = sb.free_slots() + extra;
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom), 1'($urandom));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        int r;
        int n;
        sb = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed: empty drains, extreme bytes, ignored data, busy endpoint
        send_drain(1'b1);
        offer(ACT_DRAIN, 8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h85, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'hAA, 1'b0);
        offer(ACT_DRAIN, 8'h3C, 1'b0);
        offer(ACT_DRAIN, 8'hC3, 1'b1);
        send_drain(1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b1);
        send_drain(1'b1);

        // hold the receiver off while the ring fills and refused bytes back up
        hold_len = 4000;
        hold_requests++;
        fill_ring(0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b1);
        for (int i = 0; i < 6; i++)
            send_drain(1'b1);
        wait_drained();

        for (int op = 0; op < 40; op++)
        begin
            quiet = (op % 20) < 3;
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    send_byte(8'($urandom), 1'($urandom));
            end
            else if (r < 85)
                send_drain($urandom_range(0, 3) != 0);
            else
                offer(1'($urandom), 8'($urandom), 1'($urandom));
            if (op == 20)
                wait_drained();
        end
        quiet = 1'b0;
        for (int i = 0; i < 6; i++)
            send_drain(1'b1);

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
hdl/brpd_pkg.sv
hdl/brpd_dp.sv
hdl/brpd_ctrl.sv
hdl/byte_ring_buffer_packet_drain_top.sv
tb/byte_ring_buffer_packet_drain_top_tb.sv
